/* design/uaf_pkg.sv */
package uaf_pkg;

  // register file
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RATE_W    = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOST_RATE   = 1'b0,
    REG_OUTPUT_RATE = 1'b1
  } uaf_reg_e;

  localparam logic [RATE_W-1:0] HOST_RATE_RST   = 19'd44100;
  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 19'd44100;

  // payload widths
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned LEVEL_W = 11;
  localparam int unsigned FB_W    = 25;

  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned LEVEL_MAX   = (1 << LEVEL_W) - 1;
  localparam logic [LEVEL_W-1:0] LEVEL_CAP =
    LEVEL_W'((QUEUE_DEPTH < LEVEL_MAX) ? QUEUE_DEPTH : LEVEL_MAX);

  // datapath widths
  localparam int unsigned WHOLE_W = 10;  // host_rate / 1000
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned NOM_W   = WHOLE_W + FRAC_W;
  localparam int unsigned TGT_W   = 10;
  localparam int unsigned SPAN_W  = FRAC_W + 1;
  localparam int unsigned DIFF_W  = LEVEL_W;
  localparam int unsigned FBX_W   = 29;
  localparam int unsigned BOUND_W = NOM_W + 1;

  // reciprocal constants: ceil(2^29 / 1000), ceil(2^36 / 1000), 3 * ceil(2^32 / 2000)
  localparam int unsigned WHOLE_SHIFT  = 29;
  localparam int unsigned WHOLE_PROD_W = WHOLE_SHIFT + WHOLE_W;
  localparam logic [19:0] WHOLE_RCP    = 20'd536871;
  localparam int unsigned FRAC_SHIFT   = 20;
  localparam int unsigned FRAC_PROD_W  = FRAC_SHIFT + FRAC_W;
  localparam logic [26:0] FRAC_RCP     = 27'd68719477;
  localparam int unsigned TGT_SHIFT    = 32;
  localparam int unsigned TGT_PROD_W   = TGT_SHIFT + TGT_W;
  localparam logic [22:0] TGT_RCP      = 23'd6442452;

  localparam logic [RATE_W-1:0] RATE_PER_MS = 19'd1000;

  // divider for the step by the target level
  localparam int unsigned DIV_W = DIFF_W + SPAN_W;
  localparam int unsigned DVS_W = TGT_W;
  localparam int unsigned CNT_W = 5;

  localparam logic [CNT_W-1:0] STEPS_FB = CNT_W'(DIV_W);

  localparam logic [FBX_W-1:0] FB_SAT = FBX_W'((64'd1 << FB_W) - 64'd1);

  typedef struct packed {
    logic accept;
    logic calc_whole;
    logic calc_rem;
    logic calc_frac;
    logic calc_diff;
    logic calc_prod;
    logic div_start;
    logic capture;
    logic calc_adj;
    logic load_out;
  } uaf_cmd_t;

  typedef struct packed {
    logic fresh;
    logic div_busy;
    logic out_free;
  } uaf_sts_t;

endpackage

/* design/uaf_div.sv */
module uaf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [uaf_pkg::DIV_W-1:0]  dividend_i,
  input  logic [uaf_pkg::DVS_W-1:0]  divisor_i,
  input  logic [uaf_pkg::CNT_W-1:0]  steps_i,
  output logic                       busy_o,
  output logic [uaf_pkg::DIV_W-1:0]  quotient_o
);
  import uaf_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] sh_q, sh_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   part;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign part  = {rem_q, sh_q[DIV_W-1]};
  assign ge    = part >= {1'b0, dvs_q};
  assign trial = part - {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    sh_d  = sh_q;
    dvs_d = dvs_q;
    if (start_i) begin
      // high part of the dividend seeds the remainder, low bits get shifted through
      cnt_d = steps_i;
      rem_d = DVS_W'(dividend_i >> steps_i);
      sh_d  = dividend_i << (CNT_W'(DIV_W) - steps_i);
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      rem_d = ge ? trial[DVS_W-1:0] : part[DVS_W-1:0];
      sh_d  = {sh_q[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = sh_q;

endmodule

/* design/uaf_dp.sv */
module uaf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [uaf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [uaf_pkg::RATE_W-1:0]    cfg_wdata_i,
  input  logic                          packet_ready_i,
  input  logic [uaf_pkg::TICK_W-1:0]    now_ms_i,
  input  logic [uaf_pkg::LEVEL_W-1:0]   queue_level_i,
  input  uaf_pkg::uaf_cmd_t             cmd_i,
  output uaf_pkg::uaf_sts_t             sts_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [uaf_pkg::FB_W-1:0]      feedback_o
);
  import uaf_pkg::*;

  logic [RATE_W-1:0]  host_rate_q;
  logic [RATE_W-1:0]  output_rate_q;
  logic [TICK_W-1:0]  last_tick_q;
  logic               out_valid_q;
  logic [FB_W-1:0]    feedback_q;

  logic [LEVEL_W-1:0] level_q;
  logic [WHOLE_W-1:0] whole_q;
  logic [WHOLE_W-1:0] rem_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [TGT_W-1:0]   tgt_q;
  logic               up_q;
  logic [DIFF_W-1:0]  diff_q;
  logic [SPAN_W-1:0]  span_q;
  logic [DIV_W-1:0]   prod_q;
  logic [DIV_W-1:0]   delta_q;
  logic [FBX_W-1:0]   fb_q;

  logic               div_busy;
  logic [DIV_W-1:0]   div_quo;

  logic [WHOLE_PROD_W-1:0] whole_prod;
  logic [TGT_PROD_W-1:0]   tgt_prod;
  logic [TGT_W-1:0]        tgt_raw;
  logic [RATE_W-1:0]       rem_full;
  logic [FRAC_PROD_W-1:0]  frac_prod;

  logic               fresh;
  logic [LEVEL_W-1:0] level_sat;
  logic [LEVEL_W-1:0] tgt_ext;
  logic               up;
  logic [SPAN_W-1:0]  span_up;
  logic [SPAN_W-1:0]  span_dn;
  logic [FBX_W-1:0]   nom_x;
  logic [FBX_W-1:0]   delta_x;
  logic [FBX_W-1:0]   fmax_x;
  logic [FBX_W-1:0]   fmin_x;
  logic [FBX_W-1:0]   fb_hi;
  logic [FBX_W-1:0]   fb_lo;
  logic [FB_W-1:0]    fb_out;
  logic               out_free;

  assign fresh     = packet_ready_i && (now_ms_i != last_tick_q);
  assign level_sat = (queue_level_i > LEVEL_CAP) ? LEVEL_CAP : queue_level_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o          = '0;
    sts_o.fresh    = fresh;
    sts_o.div_busy = div_busy;
    sts_o.out_free = out_free;
  end

  // division by 1000 and 2000 through scaled reciprocals, exact over the 19-bit rates
  assign whole_prod = WHOLE_PROD_W'(host_rate_q) * WHOLE_PROD_W'(WHOLE_RCP);
  assign tgt_prod   = TGT_PROD_W'(output_rate_q) * TGT_PROD_W'(TGT_RCP);
  assign tgt_raw    = tgt_prod[TGT_SHIFT +: TGT_W];
  assign rem_full   = host_rate_q - RATE_W'(whole_q) * RATE_PER_MS;
  assign frac_prod  = FRAC_PROD_W'(rem_q) * FRAC_PROD_W'(FRAC_RCP);

  uaf_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (prod_q),
    .divisor_i   (tgt_q),
    .steps_i     (STEPS_FB),
    .busy_o      (div_busy),
    .quotient_o  (div_quo)
  );

  assign tgt_ext = LEVEL_W'(tgt_q);
  assign up      = tgt_ext > level_q;
  // nominal sits inside [fmin, fmax] and both distances come from the fraction
  assign span_up = {1'b1, {FRAC_W{1'b0}}} - SPAN_W'(frac_q);
  always_comb begin
    if (host_rate_q == '0) begin
      span_dn = '0;
    end else if (rem_q == '0) begin
      span_dn = {1'b1, {FRAC_W{1'b0}}};
    end else begin
      span_dn = SPAN_W'(frac_q);
    end
  end

  assign nom_x   = FBX_W'({whole_q, frac_q});
  assign delta_x = FBX_W'(delta_q);
  assign fmax_x  = FBX_W'({(WHOLE_W + 1)'(whole_q) + (WHOLE_W + 1)'(1), {FRAC_W{1'b0}}});

  always_comb begin
    if (host_rate_q == '0) begin
      fmin_x = '0;
    end else if (rem_q != '0) begin
      fmin_x = FBX_W'({whole_q, {FRAC_W{1'b0}}});
    end else begin
      fmin_x = FBX_W'({whole_q - WHOLE_W'(1), {FRAC_W{1'b0}}});
    end
  end

  assign fb_hi  = (fb_q > fmax_x) ? fmax_x : fb_q;
  assign fb_lo  = (fb_hi < fmin_x) ? fmin_x : fb_hi;
  assign fb_out = (fb_lo > FB_SAT) ? FB_SAT[FB_W-1:0] : fb_lo[FB_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_rate_q   <= HOST_RATE_RST;
      output_rate_q <= OUTPUT_RATE_RST;
      last_tick_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (uaf_reg_e'(cfg_index_i))
          REG_HOST_RATE:   host_rate_q   <= cfg_wdata_i;
          REG_OUTPUT_RATE: output_rate_q <= cfg_wdata_i;
          default:         host_rate_q   <= host_rate_q;
        endcase
      end
      if (cmd_i.accept && fresh) begin
        last_tick_q <= now_ms_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && fresh) begin
      level_q <= level_sat;
    end
    if (cmd_i.calc_whole) begin
      whole_q <= whole_prod[WHOLE_SHIFT +: WHOLE_W];
      // a target below one sample is taken as one
      tgt_q   <= (tgt_raw == '0) ? TGT_W'(1) : tgt_raw;
    end
    if (cmd_i.calc_rem) begin
      rem_q <= rem_full[WHOLE_W-1:0];
    end
    if (cmd_i.calc_frac) begin
      frac_q <= frac_prod[FRAC_SHIFT +: FRAC_W];
    end
    if (cmd_i.capture) begin
      delta_q <= div_quo;
    end
    if (cmd_i.calc_diff) begin
      up_q   <= up;
      diff_q <= up ? (tgt_ext - level_q) : (level_q - tgt_ext);
      span_q <= up ? span_up : span_dn;
    end
    if (cmd_i.calc_prod) begin
      prod_q <= {{(DIV_W - DIFF_W){1'b0}}, diff_q} * {{(DIV_W - SPAN_W){1'b0}}, span_q};
    end
    if (cmd_i.calc_adj) begin
      if (up_q) begin
        fb_q <= nom_x + delta_x;
      end else begin
        fb_q <= (delta_x > nom_x) ? '0 : (nom_x - delta_x);
      end
    end
    if (cmd_i.load_out) begin
      feedback_q <= fb_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign feedback_o  = feedback_q;

endmodule

/* design/uaf_ctrl.sv */
module uaf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  uaf_pkg::uaf_sts_t sts_i,
  output uaf_pkg::uaf_cmd_t cmd_o
);
  import uaf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WHOLE,
    ST_REM,
    ST_FRAC,
    ST_DIFF,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ADJ,
    ST_OUT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && sts_i.fresh) begin
            state_q <= ST_WHOLE;
          end
        end
        ST_WHOLE:  state_q <= ST_REM;
        ST_REM:    state_q <= ST_FRAC;
        ST_FRAC:   state_q <= ST_DIFF;
        ST_DIFF:   state_q <= ST_MUL;
        ST_MUL:    state_q <= ST_DIV_GO;
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (!sts_i.div_busy) begin
            state_q <= ST_ADJ;
          end
        end
        ST_ADJ: state_q <= ST_OUT;
        ST_OUT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.calc_whole = state_q == ST_WHOLE;
    cmd_o.calc_rem   = state_q == ST_REM;
    cmd_o.calc_frac  = state_q == ST_FRAC;
    cmd_o.calc_diff  = state_q == ST_DIFF;
    cmd_o.calc_prod  = state_q == ST_MUL;
    cmd_o.div_start  = state_q == ST_DIV_GO;
    cmd_o.capture    = (state_q == ST_DIV_WAIT) && !sts_i.div_busy;
    cmd_o.calc_adj   = state_q == ST_ADJ;
    cmd_o.load_out   = (state_q == ST_OUT) && sts_i.out_free;
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

/* design/usb_audio_async_feedback_core.sv */
// channel  direction  handshake                  payload
// -------  ---------  -------------------------  ----------------------------------------
// in       request    in_valid_i / in_stall_o    packet_ready_i, now_ms_i, queue_level_i
// out      result     out_valid_o / out_stall_i  feedback_o
// cfg      write      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_wdata_i
//
// a request that yields a result stalls the input through five setup steps, the
// bit-serial divider (28 steps), then adjust and load
// a request with no packet or with the same tick as the last accepted one
// is dropped and does not stall the input
// a stalled output holds the next result in the load step until the register frees
// reset is asynchronous and restores both rates to 44100 and the last tick to zero;
// config writes are always taken (ready tied high)
module usb_audio_async_feedback_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [uaf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [uaf_pkg::RATE_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          packet_ready_i,
  input  logic [uaf_pkg::TICK_W-1:0]    now_ms_i,
  input  logic [uaf_pkg::LEVEL_W-1:0]   queue_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [uaf_pkg::FB_W-1:0]      feedback_o
);
  import uaf_pkg::*;

  uaf_cmd_t cmd;
  uaf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  uaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uaf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .packet_ready_i (packet_ready_i),
    .now_ms_i       (now_ms_i),
    .queue_level_i  (queue_level_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .feedback_o     (feedback_o)
  );

  // a fresh packet starts the computation and blocks further requests
  a_fresh_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts.fresh) |=> in_stall_o)
    else $error("fresh packet did not start a computation");

  // a dropped request leaves the block free
  a_drop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !sts.fresh) |=> !in_stall_o)
    else $error("dropped request stalled the input");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result appeared without a load");

endmodule
